### rtl/pfx_pkg.sv
// Shared types and constants for the packed field extractor.
// Used by pfx_parser, pfx_rsp_fifo and the top level.
package pfx_pkg;

   localparam int unsigned ELEM_BITS  = 64;
   localparam int unsigned FIELD_BITS = 32;

   // result kind
   localparam logic KIND_ELEM = 1'b0;
   localparam logic KIND_END  = 1'b1;

   // end-of-message status
   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_TRUNC     = 3'd1;
   localparam logic [2:0] ST_VARINT    = 3'd2;
   localparam logic [2:0] ST_WIRE_TYPE = 3'd3;
   localparam logic [2:0] ST_BAD_PACK  = 3'd4;

   // protobuf wire types
   localparam logic [2:0] WT_VARINT  = 3'd0;
   localparam logic [2:0] WT_FIXED64 = 3'd1;
   localparam logic [2:0] WT_LEN     = 3'd2;
   localparam logic [2:0] WT_FIXED32 = 3'd5;

   typedef struct packed {
      logic                 kind;
      logic [ELEM_BITS-1:0] bits;
      logic                 grp;
      logic [2:0]           status;
      logic                 eor;
   } rsp_item_type;

   // results of one parsed byte; second slot used only with the first
   typedef struct packed {
      logic         push0;
      logic         push1;
      rsp_item_type item0;
      rsp_item_type item1;
   } push_type;

endpackage

### rtl/pfx_parser.sv
// Input register and per-byte protobuf wire format step.
// Depends on pfx_pkg; feeds pfx_rsp_fifo with up to two results per byte.
module pfx_parser #(
   parameter int unsigned LENGTH_BITS = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [pfx_pkg::FIELD_BITS-1:0]      target_field,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [7:0]                          req_tdata,
   input  logic                                req_tlast,
   input  logic                                room,
   output pfx_pkg::push_type                   push
);
   import pfx_pkg::*;

   typedef enum logic [6:0] {
      PH_TAG     = 7'b0000001,
      PH_LEN     = 7'b0000010,
      PH_VSKIP   = 7'b0000100,
      PH_SKIP    = 7'b0001000,
      PH_PAYLOAD = 7'b0010000,
      PH_BADPACK = 7'b0100000,
      PH_STOPPED = 7'b1000000
   } phase_type;

   // input register
   logic       stage_valid_ff, stage_valid_in;
   logic [7:0] stage_byte_ff;
   logic       stage_last_ff;
   logic       advance;

   // parse state
   phase_type              phase_ff, phase_in;
   logic [63:0]            vacc_ff, vacc_in;
   logic [3:0]             vshift_ff, vshift_in;
   logic                   match_ff, match_in;
   logic [LENGTH_BITS-1:0] brem_ff, brem_in;
   logic [63:0]            wacc_ff, wacc_in;
   logic [2:0]             widx_ff, widx_in;
   logic                   first_ff, first_in;
   logic [2:0]             err_ff, err_in;

   logic [7:0]             b;
   logic [6:0]             shamt7;
   logic [63:0]            vfed;
   logic                   vdone, vovf;
   logic [31:0]            tag_field;
   logic [2:0]             tag_wt;
   logic                   len_too_big;
   logic [LENGTH_BITS-1:0] len_val;
   logic [LENGTH_BITS-1:0] brem_dec;
   logic [63:0]            wnew;
   logic                   elem_emit;
   logic [63:0]            elem_bits;
   logic                   elem_grp;
   logic [2:0]             end_status;

   assign advance    = stage_valid_ff & room;
   assign req_tready = ~stage_valid_ff | room;

   always_comb begin
      stage_valid_in = stage_valid_ff;
      if (req_tvalid && req_tready) begin
         stage_valid_in = 1'b1;
      end else if (advance) begin
         stage_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
      end
      if (req_tvalid && req_tready) begin
         stage_byte_ff <= req_tdata;
         stage_last_ff <= req_tlast;
      end
   end

   assign b      = stage_byte_ff;
   // 7 * shift, at most 63
   assign shamt7 = {vshift_ff, 3'b000} - {3'b000, vshift_ff};
   assign vfed   = vacc_ff | ({57'd0, b[6:0]} << shamt7[5:0]);
   assign vdone  = ~b[7];
   assign vovf   = b[7] && (vshift_ff >= 4'd9);

   assign tag_field   = vfed[34:3];
   assign tag_wt      = vfed[2:0];
   assign len_too_big = (vfed >> LENGTH_BITS) != 64'd0;
   assign len_val     = vfed[LENGTH_BITS-1:0];
   assign brem_dec    = brem_ff - {{(LENGTH_BITS-1){1'b0}}, 1'b1};
   assign wnew        = wacc_ff | ({56'd0, b} << {widx_ff, 3'b000});

   always_comb begin
      phase_in  = phase_ff;
      vacc_in   = vacc_ff;
      vshift_in = vshift_ff;
      match_in  = match_ff;
      brem_in   = brem_ff;
      wacc_in   = wacc_ff;
      widx_in   = widx_ff;
      first_in  = first_ff;
      err_in    = err_ff;
      elem_emit = 1'b0;
      elem_bits = wnew;
      elem_grp  = first_ff;
      end_status = ST_OK;

      unique case (phase_ff) inside
         PH_TAG, PH_LEN, PH_VSKIP: begin
            vacc_in = vfed;
            if (vovf) begin
               err_in   = ST_VARINT;
               phase_in = PH_STOPPED;
            end else if (!vdone) begin
               vshift_in = vshift_ff + 4'd1;
            end else begin
               vacc_in   = 64'd0;
               vshift_in = 4'd0;
               if (phase_ff == PH_TAG) begin
                  match_in = (tag_field == target_field) && (tag_wt == WT_LEN);
                  case (tag_wt)
                     WT_VARINT:  phase_in = PH_VSKIP;
                     WT_FIXED64: begin
                        phase_in = PH_SKIP;
                        brem_in  = LENGTH_BITS'(8);
                     end
                     WT_LEN:     phase_in = PH_LEN;
                     WT_FIXED32: begin
                        phase_in = PH_SKIP;
                        brem_in  = LENGTH_BITS'(4);
                     end
                     default: begin
                        err_in   = ST_WIRE_TYPE;
                        phase_in = PH_STOPPED;
                     end
                  endcase
               end else if (phase_ff == PH_LEN) begin
                  if (len_too_big) begin
                     err_in   = ST_TRUNC;
                     phase_in = PH_STOPPED;
                  end else begin
                     phase_in = PH_TAG;
                     if (len_val != '0) begin
                        brem_in = len_val;
                        if (!match_ff) begin
                           phase_in = PH_SKIP;
                        end else if (len_val[2:0] != 3'd0) begin
                           phase_in = PH_BADPACK;
                        end else begin
                           phase_in = PH_PAYLOAD;
                           wacc_in  = 64'd0;
                           widx_in  = 3'd0;
                           first_in = 1'b1;
                        end
                     end
                  end
               end else begin
                  phase_in = PH_TAG;
               end
            end
         end
         PH_SKIP: begin
            brem_in = brem_dec;
            if (brem_dec == '0) begin
               phase_in = PH_TAG;
            end
         end
         PH_PAYLOAD: begin
            if (widx_ff == 3'd7) begin
               elem_emit = 1'b1;
               first_in  = 1'b0;
               wacc_in   = 64'd0;
               widx_in   = 3'd0;
            end else begin
               wacc_in = wnew;
               widx_in = widx_ff + 3'd1;
            end
            brem_in = brem_dec;
            if (brem_dec == '0) begin
               phase_in = PH_TAG;
            end
         end
         PH_BADPACK: begin
            brem_in = brem_dec;
            if (brem_dec == '0) begin
               err_in   = ST_BAD_PACK;
               phase_in = PH_STOPPED;
            end
         end
         PH_STOPPED: begin
         end
         default: begin
         end
      endcase

      if (err_in != ST_OK) begin
         end_status = err_in;
      end else if (phase_in == PH_TAG && vshift_in == 4'd0) begin
         end_status = ST_OK;
      end else begin
         end_status = ST_TRUNC;
      end

      // end of message: back to the start of a new one
      if (stage_last_ff) begin
         phase_in  = PH_TAG;
         vacc_in   = 64'd0;
         vshift_in = 4'd0;
         match_in  = 1'b0;
         brem_in   = '0;
         wacc_in   = 64'd0;
         widx_in   = 3'd0;
         first_in  = 1'b0;
         err_in    = ST_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_TAG;
         vacc_ff   <= 64'd0;
         vshift_ff <= 4'd0;
         match_ff  <= 1'b0;
         brem_ff   <= '0;
         wacc_ff   <= 64'd0;
         widx_ff   <= 3'd0;
         first_ff  <= 1'b0;
         err_ff    <= ST_OK;
      end else if (advance) begin
         phase_ff  <= phase_in;
         vacc_ff   <= vacc_in;
         vshift_ff <= vshift_in;
         match_ff  <= match_in;
         brem_ff   <= brem_in;
         wacc_ff   <= wacc_in;
         widx_ff   <= widx_in;
         first_ff  <= first_in;
         err_ff    <= err_in;
      end
   end

   // results are compacted into slot 0 first
   always_comb begin
      rsp_item_type elem_item;
      rsp_item_type end_item;
      elem_item.kind   = KIND_ELEM;
      elem_item.bits   = elem_bits;
      elem_item.grp    = elem_grp;
      elem_item.status = ST_OK;
      elem_item.eor    = ~stage_last_ff;
      end_item.kind    = KIND_END;
      end_item.bits    = 64'd0;
      end_item.grp     = 1'b0;
      end_item.status  = end_status;
      end_item.eor     = 1'b1;

      push.item0 = elem_emit ? elem_item : end_item;
      push.item1 = end_item;
      push.push0 = advance & (elem_emit | stage_last_ff);
      push.push1 = advance & elem_emit & stage_last_ff;
   end

endmodule

### rtl/pfx_rsp_fifo.sv
// Four-entry result queue: takes up to two results per cycle, sends one.
// Depends on pfx_pkg for the result item and push types.
module pfx_rsp_fifo (
   input  logic                   clock,
   input  logic                   reset,
   input  pfx_pkg::push_type      push,
   output logic                   room,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output pfx_pkg::rsp_item_type  rsp_item
);
   import pfx_pkg::*;

   localparam int unsigned DEPTH = 4;
   localparam int unsigned PW    = $clog2(DEPTH);
   localparam int unsigned CW    = $clog2(DEPTH + 1);

   rsp_item_type    mem [DEPTH];
   logic [PW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   count_ff, count_in;
   logic            pop;
   logic [CW-1:0]   push_n;
   logic [PW-1:0]   wr_next;

   assign pop        = rsp_tvalid & rsp_tready;
   assign rsp_tvalid = count_ff != '0;
   assign room       = count_ff <= CW'(DEPTH - 2);
   assign push_n     = CW'(push.push0) + CW'(push.push1);
   assign wr_next    = wr_ptr_ff + PW'(1);

   always_comb begin
      wr_ptr_in = wr_ptr_ff + PW'(push_n);
      rd_ptr_in = rd_ptr_ff + PW'(pop);
      count_in  = count_ff + push_n - CW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.push0) begin
         mem[wr_ptr_ff] <= push.item0;
      end
      if (push.push1) begin
         mem[wr_next] <= push.item1;
      end
   end

   assign rsp_item = mem[rd_ptr_ff];

endmodule

### rtl/protobuf_packed_field_extractor.sv
// Packed 64-bit field extractor for protobuf messages, top level.
// Depends on pfx_pkg, pfx_parser and pfx_rsp_fifo.
//
// Usage:
//   req_*  : message bytes, one per request; tlast marks the final byte.
//   rsp_*  : results. tuser[0] is the kind (element word or end of message),
//            tuser[1] flags the first word of a new target field occurrence.
//            tdata carries the element word and the end status; tlast marks
//            the last result caused by one request byte.
//   csr_*  : write of the target field number; write only while idle.
// Path: a taken byte waits in the input register; its results enter the queue.
// Throughput: one byte per cycle while the result queue has room; set by the single
//   parse step between the input register and the four-entry result queue. A byte
//   that finishes an element and ends the message gives two results, sent in turn.
// Reset: target field returns to 1, parsing restarts at a tag, queue empties.
// Stall: with rsp_tready low the queue fills, the input register holds and
//   req_tready drops; nothing is lost or repeated.
// Results of a message that ends with an error status must be discarded.
module protobuf_packed_field_extractor #(
   parameter int unsigned LENGTH_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,   // [63:0] element_bits, [66:64] status, rest zero
   output logic [1:0]  rsp_tuser,   // [0] result_kind, [1] group_start
   output logic        rsp_tlast,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [31:0] csr_data
);
   import pfx_pkg::*;

   logic [FIELD_BITS-1:0] target_ff;
   push_type              push;
   logic                  room;
   rsp_item_type          rsp_item;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff <= FIELD_BITS'(1);
      end else if (csr_valid && csr_ready) begin
         target_ff <= csr_data;
      end
   end

   pfx_parser #(
      .LENGTH_BITS (LENGTH_BITS)
   ) u_parser (
      .clock        (clock),
      .reset        (reset),
      .target_field (target_ff),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .req_tlast    (req_tlast),
      .room         (room),
      .push         (push)
   );

   pfx_rsp_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .room       (room),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_item   (rsp_item)
   );

   assign rsp_tdata = {5'd0, rsp_item.status, rsp_item.bits};
   assign rsp_tuser = {rsp_item.grp, rsp_item.kind};
   assign rsp_tlast = rsp_item.eor;

endmodule
